>>> hw/rtl/lsp_pkg.sv
`timescale 1ns / 1ps

package lsp_pkg;

  localparam int NUM_SENSORS   = 5;
  localparam int MID_SENSOR    = 2;
  localparam int THR_BITS      = 10;
  localparam int GAIN_BITS     = 8;
  localparam int MASK_BITS     = 5;
  localparam int ERR_BITS      = 6;
  localparam int DRIVE_BITS    = 13;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 10'd512;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET      = 8'd1;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN      = 2'd1;

  // frame opcodes
  localparam logic OP_RUN       = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;

  // control that moves with the frame register into the two datapath parts
  typedef struct packed {
    logic advance;
    logic calibrate;
  } stage_ctl_t;

  // mask to position error, unlisted masks give zero
  function automatic logic signed [ERR_BITS-1:0] pos_error(input logic [MASK_BITS-1:0] mask);
    logic signed [ERR_BITS-1:0] err;
    case (mask)
      5'd16:   err = -6'sd16;
      5'd24:   err = -6'sd9;
      5'd8:    err = -6'sd4;
      5'd12:   err = -6'sd1;
      5'd4:    err = 6'sd0;
      5'd6:    err = 6'sd1;
      5'd2:    err = 6'sd4;
      5'd3:    err = 6'sd9;
      5'd1:    err = 6'sd16;
      default: err = 6'sd0;
    endcase
    return err;
  endfunction

endpackage

>>> hw/rtl/lsp_if.sv
`timescale 1ns / 1ps

interface lsp_frame_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [SAMPLE_BITS-1:0] sample_zero;
  logic [SAMPLE_BITS-1:0] sample_one;
  logic [SAMPLE_BITS-1:0] sample_two;
  logic [SAMPLE_BITS-1:0] sample_three;
  logic [SAMPLE_BITS-1:0] sample_four;

  modport source (
    output valid, opcode, sample_zero, sample_one, sample_two, sample_three, sample_four,
    input  ready
  );
  modport sink (
    input  valid, opcode, sample_zero, sample_one, sample_two, sample_three, sample_four,
    output ready
  );
endinterface

interface lsp_result_if;
  logic                                 valid;
  logic                                 ready;
  logic        [lsp_pkg::MASK_BITS-1:0]  detect_mask;
  logic signed [lsp_pkg::ERR_BITS-1:0]   position_error;
  logic signed [lsp_pkg::DRIVE_BITS-1:0] drive;

  modport source (output valid, detect_mask, position_error, drive, input ready);
  modport sink   (input valid, detect_mask, position_error, drive, output ready);
endinterface

interface lsp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lsp_pkg::CFG_IDX_BITS-1:0]   index;
  logic [lsp_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lsp_cfg_regs.sv
`timescale 1ns / 1ps

module lsp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lsp_cfg_if.sink                         cfg,
  output logic [lsp_pkg::THR_BITS-1:0]    threshold_o,
  output logic [lsp_pkg::GAIN_BITS-1:0]   gain_o
);
  import lsp_pkg::*;

  logic [THR_BITS-1:0]  threshold_q;
  logic [GAIN_BITS-1:0] gain_q;

  assign cfg.ready = 1'b1;

  // writes to indexes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      gain_q      <= GAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_THRESHOLD: threshold_q <= cfg.data[THR_BITS-1:0];
        CFG_GAIN:      gain_q      <= cfg.data[GAIN_BITS-1:0];
        default:       ;
      endcase
    end
  end

  assign threshold_o = threshold_q;
  assign gain_o      = gain_q;

endmodule

>>> hw/rtl/lsp_offset_detect.sv
`timescale 1ns / 1ps

module lsp_offset_detect #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsp_pkg::stage_ctl_t           ctl_i,
  input  logic [SAMPLE_BITS-1:0]        samples_i [lsp_pkg::NUM_SENSORS],
  input  logic [lsp_pkg::THR_BITS-1:0]  threshold_i,
  output logic [lsp_pkg::MASK_BITS-1:0] mask_o
);
  import lsp_pkg::*;

  localparam int OFS_BITS  = SAMPLE_BITS + 1;
  // wide enough for sample plus offset and for the zero-extended threshold
  localparam int NORM_BITS = (SAMPLE_BITS + 2 > THR_BITS + 1) ? SAMPLE_BITS + 2 : THR_BITS + 1;

  logic [OFS_BITS-1:0]  offset_q [NUM_SENSORS];
  logic [OFS_BITS-1:0]  offset_d [NUM_SENSORS];
  logic [NORM_BITS-1:0] norm     [NUM_SENSORS];
  logic [NORM_BITS-1:0] thr_ext;
  logic                 cal_write;

  assign cal_write = ctl_i.advance && ctl_i.calibrate;
  assign thr_ext   = {{(NORM_BITS-THR_BITS){1'b0}}, threshold_i};

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      offset_d[i] = {1'b0, samples_i[MID_SENSOR]} - {1'b0, samples_i[i]};
      norm[i]     = {{(NORM_BITS-SAMPLE_BITS){1'b0}}, samples_i[i]}
                  + {{(NORM_BITS-OFS_BITS){offset_q[i][OFS_BITS-1]}}, offset_q[i]};
      mask_o[i]   = $signed(norm[i]) > $signed(thr_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        offset_q[i] <= '0;
      end
    end else if (cal_write) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        offset_q[i] <= offset_d[i];
      end
    end
  end

endmodule

>>> hw/rtl/lsp_result_stage.sv
`timescale 1ns / 1ps

module lsp_result_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsp_pkg::stage_ctl_t           ctl_i,
  input  logic [lsp_pkg::MASK_BITS-1:0] mask_i,
  input  logic [lsp_pkg::GAIN_BITS-1:0] gain_i,
  lsp_result_if.source                  result
);
  import lsp_pkg::*;

  localparam int PROD_BITS = GAIN_BITS + 1 + ERR_BITS;

  logic                         load;
  logic signed [ERR_BITS-1:0]   err;
  logic signed [PROD_BITS-1:0]  gain_s;
  logic signed [PROD_BITS-1:0]  err_s;
  logic signed [PROD_BITS-1:0]  prod;

  logic                         valid_q;
  logic        [MASK_BITS-1:0]  mask_q;
  logic signed [ERR_BITS-1:0]   err_q;
  logic signed [DRIVE_BITS-1:0] drive_q;

  assign load   = ctl_i.advance && !ctl_i.calibrate;
  assign err    = pos_error(mask_i);
  assign gain_s = $signed({{(PROD_BITS-GAIN_BITS){1'b0}}, gain_i});
  assign err_s  = $signed({{(PROD_BITS-ERR_BITS){err[ERR_BITS-1]}}, err});
  assign prod   = gain_s * err_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (result.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mask_q  <= mask_i;
      err_q   <= err;
      drive_q <= prod[DRIVE_BITS-1:0];
    end
  end

  assign result.valid          = valid_q;
  assign result.detect_mask    = mask_q;
  assign result.position_error = err_q;
  assign result.drive          = drive_q;

endmodule

>>> hw/rtl/line_sensor_position_error_core.sv
`timescale 1ns / 1ps

// Line-sensor position error core. Takes one frame per clock cycle while results are
// taken: a frame is captured in the input register, then normalized, thresholded and
// table-mapped, and its result (detect mask, position error, gain times error) is
// loaded into the output register once that register is empty or being drained.
// A calibrate frame updates the five sensor offsets when it leaves the input
// register and produces no result. The offset store, threshold (512) and gain (1)
// are set by reset. Throughput is one frame per cycle while the result side takes
// one per cycle; a stalled result holds the output register and one more frame may
// wait in the input register.

module line_sensor_position_error_core #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsp_frame_if.sink     frame,
  lsp_result_if.source  result,
  lsp_cfg_if.sink       cfg
);
  import lsp_pkg::*;

  logic                   s1_valid_q;
  logic                   s1_op_q;
  logic [SAMPLE_BITS-1:0] s1_samp_q [NUM_SENSORS];

  stage_ctl_t             ctl;
  logic                   out_free;
  logic                   in_xfer;
  logic [THR_BITS-1:0]    threshold;
  logic [GAIN_BITS-1:0]   gain;
  logic [MASK_BITS-1:0]   mask;

  // output register can take a new result when empty or being drained
  assign out_free      = !result.valid || result.ready;
  assign ctl.advance   = s1_valid_q && out_free;
  assign ctl.calibrate = (s1_op_q == OP_CALIBRATE);
  assign frame.ready   = !s1_valid_q || ctl.advance;
  assign in_xfer       = frame.valid && frame.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (frame.ready) begin
      s1_valid_q <= frame.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q      <= frame.opcode;
      s1_samp_q[0] <= frame.sample_zero;
      s1_samp_q[1] <= frame.sample_one;
      s1_samp_q[2] <= frame.sample_two;
      s1_samp_q[3] <= frame.sample_three;
      s1_samp_q[4] <= frame.sample_four;
    end
  end

  lsp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg         (cfg),
    .threshold_o (threshold),
    .gain_o      (gain)
  );

  lsp_offset_detect #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .samples_i   (s1_samp_q),
    .threshold_i (threshold),
    .mask_o      (mask)
  );

  lsp_result_stage u_result (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .mask_i (mask),
    .gain_i (gain),
    .result (result)
  );

  // a run frame leaving the input register always lands in the output register
  a_run_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.advance && s1_op_q == OP_RUN) |=> result.valid)
    else $error("run frame did not produce a result");

  // a calibrate frame never produces a result
  a_cal_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.advance && s1_op_q == OP_CALIBRATE && result.ready) |=> !result.valid)
    else $error("calibrate frame produced a result");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> (result.position_error <= 6'sd16 && result.position_error >= -6'sd16))
    else $error("position error out of range");

  a_empty_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result.valid && result.detect_mask == '0) |->
      (result.position_error == '0 && result.drive == '0))
    else $error("empty mask with nonzero error");

endmodule

>>> verif/line_sensor_position_error_core_tb.sv
`timescale 1ns / 1ps

module line_sensor_position_error_core_tb;
  import lsp_pkg::*;

  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 4;

  // masks that the position table lists, in table order
  localparam logic [8:0][MASK_BITS-1:0] LINE_MASKS =
      {5'd16, 5'd24, 5'd8, 5'd12, 5'd4, 5'd6, 5'd2, 5'd3, 5'd1};

  typedef struct packed {
    logic                                 op;
    logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] smp;
  } frame_t;

  typedef struct packed {
    logic        [MASK_BITS-1:0]  mask;
    logic signed [ERR_BITS-1:0]   err;
    logic signed [DRIVE_BITS-1:0] drive;
  } line_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lsp_frame_if #(.SAMPLE_BITS(SAMPLE_W)) frame_bus ();
  lsp_result_if                          result_bus ();
  lsp_cfg_if                             cfg_bus ();

  line_sensor_position_error_core #(.SAMPLE_BITS(SAMPLE_W)) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .frame  (frame_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #6 clk = ~clk;

  // shadow copy of the block state
  logic [THR_BITS-1:0]  thr_reg;
  logic [GAIN_BITS-1:0] gain_reg;
  int                   sensor_offset [NUM_SENSORS];

  line_result_t expected_results [$];
  int           fail_count = 0;
  int           sink_hold  = 0;
  bit           no_gaps    = 1'b0;
  int           burst_left = 0;
  int           idle_cycles = 0;

  function automatic int mask_error(input logic [MASK_BITS-1:0] m);
    case (m)
      5'b10000: return -16;
      5'b11000: return -9;
      5'b01000: return -4;
      5'b01100: return -1;
      5'b00110: return 1;
      5'b00010: return 4;
      5'b00011: return 9;
      5'b00001: return 16;
      default:  return 0;  // centered line and every unlisted mask
    endcase
  endfunction

  function automatic line_result_t predict_run(input frame_t f);
    line_result_t r;
    int           norm;
    int           err;
    r.mask = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      norm = int'(f.smp[i]) + sensor_offset[i];
      if (norm > int'(thr_reg)) r.mask[i] = 1'b1;
    end
    err     = mask_error(r.mask);
    r.err   = ERR_BITS'(err);
    r.drive = DRIVE_BITS'(int'(gain_reg) * err);
    return r;
  endfunction

  function automatic frame_t make_frame(input logic op, input int s0, input int s1,
                                        input int s2, input int s3, input int s4);
    frame_t f;
    f.op     = op;
    f.smp[0] = SAMPLE_W'(s0);
    f.smp[1] = SAMPLE_W'(s1);
    f.smp[2] = SAMPLE_W'(s2);
    f.smp[3] = SAMPLE_W'(s3);
    f.smp[4] = SAMPLE_W'(s4);
    return f;
  endfunction

  // run frame with hi on the sensors set in mask, lo on the rest
  function automatic frame_t mask_frame(input logic [MASK_BITS-1:0] m, input int hi,
                                        input int lo);
    frame_t f;
    f.op = OP_RUN;
    for (int i = 0; i < NUM_SENSORS; i++) f.smp[i] = SAMPLE_W'(m[i] ? hi : lo);
    return f;
  endfunction

  // sample that puts sensor i above or below the threshold, edges favored
  function automatic int target_sample(input int i, input bit above);
    int lo;
    int hi;
    int r;
    lo = above ? int'(thr_reg) - sensor_offset[i] + 1 : 0;
    hi = above ? SAMPLE_MAX : int'(thr_reg) - sensor_offset[i];
    if (lo < 0) lo = 0;
    if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
    if (lo > hi) return $urandom_range(SAMPLE_MAX, 0);
    r = $urandom_range(3, 0);
    case (r)
      0:       return above ? lo : hi;
      1:       return above ? ((lo + 3 > hi) ? hi : lo + $urandom_range(3, 0))
                            : ((hi - 3 < lo) ? lo : hi - $urandom_range(3, 0));
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // offers one frame, waits for its transfer, updates the shadow state, adds random gaps unless no_gaps
  task automatic send_frame(input frame_t f);
    int gap;
    frame_bus.valid        <= 1'b1;
    frame_bus.opcode       <= f.op;
    frame_bus.sample_zero  <= f.smp[0];
    frame_bus.sample_one   <= f.smp[1];
    frame_bus.sample_two   <= f.smp[2];
    frame_bus.sample_three <= f.smp[3];
    frame_bus.sample_four  <= f.smp[4];
    @(posedge clk);
    while (!frame_bus.ready) @(posedge clk);
    if (f.op == OP_CALIBRATE) begin
      for (int i = 0; i < NUM_SENSORS; i++)
        sensor_offset[i] = int'(f.smp[MID_SENSOR]) - int'(f.smp[i]);
    end else begin
      expected_results.push_back(predict_run(f));
    end
    if (!no_gaps) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 5) : $urandom_range(4, 0);
        burst_left = $urandom_range(12, 1);
        if (gap > 0) begin
          frame_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_reg  = data[THR_BITS-1:0];
      CFG_GAIN:      gain_reg = data[GAIN_BITS-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and let every pending result and any calibrate frame drain
  task automatic wait_idle();
    frame_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic test_reset_values();
    // offsets cleared, threshold 512, gain 1
    for (int k = 0; k < 9; k++) send_frame(mask_frame(LINE_MASKS[k], SAMPLE_MAX, 0));
    send_frame(mask_frame(5'b00000, SAMPLE_MAX, 0));
    send_frame(mask_frame(5'b11111, SAMPLE_MAX, 0));
    send_frame(mask_frame(5'b10101, SAMPLE_MAX, 0));
    send_frame(mask_frame(5'b01010, SAMPLE_MAX, 0));
    // strictly greater: 512 is not above, 513 is
    send_frame(mask_frame(5'b11111, 512, 512));
    send_frame(mask_frame(5'b11111, 513, 512));
    wait_idle();
  endtask

  task automatic test_calibration();
    // largest positive offsets, normalized sums up to twice full scale
    send_frame(make_frame(OP_CALIBRATE, 0, 0, SAMPLE_MAX, 0, 0));
    wait_idle();
    write_reg(CFG_THRESHOLD, 10'd1023);
    send_frame(mask_frame(5'b11111, SAMPLE_MAX, 0));
    send_frame(make_frame(OP_RUN, 0, 0, 0, 1, 0));
    // largest negative offsets, sums go below zero
    send_frame(make_frame(OP_CALIBRATE, SAMPLE_MAX, SAMPLE_MAX, 0, SAMPLE_MAX, SAMPLE_MAX));
    wait_idle();
    write_reg(CFG_THRESHOLD, 10'd0);
    send_frame(mask_frame(5'b00000, SAMPLE_MAX, 0));
    send_frame(mask_frame(5'b11111, SAMPLE_MAX, 0));
    send_frame(make_frame(OP_CALIBRATE, 300, 300, 300, 300, 300));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_THRESHOLD, 10'd0);
    write_reg(CFG_GAIN, 10'h3FF);  // upper data bits drop, gain 255
    send_frame(mask_frame(5'b00001, SAMPLE_MAX, 0));
    send_frame(mask_frame(5'b10000, SAMPLE_MAX, 0));
    wait_idle();
    // indexes past the register list change nothing
    write_reg(2'd2, 10'h155);
    write_reg(2'd3, 10'h2AA);
    send_frame(mask_frame(5'b00011, 1, 0));
    wait_idle();
    write_reg(CFG_THRESHOLD, 10'd1023);
    write_reg(CFG_GAIN, 10'h100);  // gain 0
    send_frame(mask_frame(5'b11111, SAMPLE_MAX, 0));
    wait_idle();
    write_reg(CFG_THRESHOLD, 10'd100);
    send_frame(mask_frame(5'b01000, SAMPLE_MAX, 0));
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_GAIN, 10'd7);
    no_gaps   = 1'b1;
    sink_hold = 300;
    for (int n = 0; n < 30; n++)
      send_frame(mask_frame(LINE_MASKS[n % 9], SAMPLE_MAX, 0));
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_frames();
    frame_t               f;
    logic [MASK_BITS-1:0] want;
    int                   pick;
    int                   mid;
    int                   v;
    for (int phase = 0; phase < 12; phase++) begin
      pick = $urandom_range(5, 0);
      case (pick)
        0:       write_reg(CFG_THRESHOLD, 10'd0);
        1:       write_reg(CFG_THRESHOLD, 10'd1023);
        2:       write_reg(CFG_THRESHOLD, 10'd512);
        default: write_reg(CFG_THRESHOLD, CFG_DATA_BITS'($urandom_range(1023, 0)));
      endcase
      pick = $urandom_range(4, 0);
      case (pick)
        0:       write_reg(CFG_GAIN, 10'd0);
        1:       write_reg(CFG_GAIN, 10'h3FF);
        default: write_reg(CFG_GAIN, CFG_DATA_BITS'($urandom_range(1023, 0)));
      endcase
      if ($urandom_range(3, 0) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(3, 2)), CFG_DATA_BITS'($urandom()));
      no_gaps = (phase % 4 == 3);
      for (int n = 0; n < 140; n++) begin
        pick = $urandom_range(99, 0);
        if (pick < 12) begin
          // calibrate, each sensor either random or close to a shared random level
          f.op = OP_CALIBRATE;
          mid  = $urandom_range(SAMPLE_MAX, 0);
          for (int i = 0; i < NUM_SENSORS; i++) begin
            if ($urandom_range(1, 0)) begin
              f.smp[i] = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
            end else begin
              v = mid + $urandom_range(80, 0) - 40;
              if (v < 0) v = 0;
              if (v > SAMPLE_MAX) v = SAMPLE_MAX;
              f.smp[i] = SAMPLE_W'(v);
            end
          end
        end else if (pick < 77) begin
          // steer the frame toward a chosen mask
          want = ($urandom_range(9, 0) < 7) ? LINE_MASKS[$urandom_range(8, 0)]
                                            : MASK_BITS'($urandom());
          f.op = OP_RUN;
          for (int i = 0; i < NUM_SENSORS; i++) f.smp[i] = SAMPLE_W'(target_sample(i, want[i]));
        end else begin
          f.op = OP_RUN;
          for (int i = 0; i < NUM_SENSORS; i++)
            f.smp[i] = SAMPLE_W'($urandom_range(SAMPLE_MAX, 0));
        end
        send_frame(f);
      end
      no_gaps = 1'b0;
      wait_idle();
    end
  endtask

  // result side stalls on its own changing pattern, and holds ready low while sink_hold runs down
  initial begin : result_sink
    int unsigned mode;
    int unsigned pattern;
    int          tick;
    tick             = 0;
    mode             = 0;
    pattern          = 0;
    result_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (tick == 0) begin
        mode    = $urandom_range(2, 0);
        pattern = $urandom();
        tick    = $urandom_range(96, 16);
      end
      tick--;
      if (sink_hold > 0) begin
        result_bus.ready <= 1'b0;
        sink_hold--;
      end else begin
        case (mode)
          0:       result_bus.ready <= 1'b1;
          1:       result_bus.ready <= ($urandom_range(99, 0) >= 35);
          default: begin
            result_bus.ready <= pattern[0];
            pattern = {pattern[0], pattern[31:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    line_result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: detect_mask %0d position_error %0d drive %0d",
               result_bus.detect_mask, result_bus.position_error, result_bus.drive);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_bus.detect_mask !== want.mask) begin
          $error("detect_mask: expected %0d, actual %0d", want.mask, result_bus.detect_mask);
          fail_count++;
        end
        if (result_bus.position_error !== want.err) begin
          $error("position_error: expected %0d, actual %0d", want.err,
                 result_bus.position_error);
          fail_count++;
        end
        if (result_bus.drive !== want.drive) begin
          $error("drive: expected %0d, actual %0d", want.drive, result_bus.drive);
          fail_count++;
        end
      end
    end
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : test_sequence
    rst_n                  = 1'b0;
    frame_bus.valid        = 1'b0;
    frame_bus.opcode       = OP_RUN;
    frame_bus.sample_zero  = '0;
    frame_bus.sample_one   = '0;
    frame_bus.sample_two   = '0;
    frame_bus.sample_three = '0;
    frame_bus.sample_four  = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_THRESHOLD;
    cfg_bus.data           = '0;
    thr_reg                = THRESHOLD_RESET;
    gain_reg               = GAIN_RESET;
    for (int i = 0; i < NUM_SENSORS; i++) sensor_offset[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_calibration();
    test_register_extremes();
    test_backpressure();
    test_random_frames();
    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("results never arrived: %0d", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
